[sv/lms_adaptive_fir_top_assert.svh]
// Assertion macros used by the control unit (lmsaf_ctrl) of the adaptive filter.
`ifndef LMS_ADAPTIVE_FIR_TOP_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LMSAF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LMSAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LMSAF_ASSERT_SAME(lbl, ante, cons, msg)
`define LMSAF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/lmsaf_pkg.sv]
package lmsaf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 32;
    localparam int STEP_W      = 16;
    localparam int TAPS_W      = 7;
    localparam int MUL_A_W     = 33;
    localparam int PROD_W      = MUL_A_W + SAMPLE_W;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int DEF_TAPS    = 64;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAPS_IN_USE = 1'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIR,
        ST_FIR_DRAIN,
        ST_ERR,
        ST_MUE,
        ST_LOAD_MU,
        ST_UPD,
        ST_UPD_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic ready;
        logic clearing;
        logic issue;
        logic upd_mode;
        logic stage2;
        logic form_err;
        logic mul_mue;
        logic load_me;
        logic finish;
    } ctrl_t;

endpackage

[sv/lmsaf_ram.sv]
module lmsaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/lmsaf_mul.sv]
module lmsaf_mul (
    input  logic                                 clk,
    input  logic signed [lmsaf_pkg::MUL_A_W-1:0] a,
    input  logic signed [lmsaf_pkg::SAMPLE_W-1:0] b,
    output logic signed [lmsaf_pkg::PROD_W-1:0]  prod
);

    import lmsaf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[sv/lmsaf_ctrl.sv]
`include "lms_adaptive_fir_top_assert.svh"

module lmsaf_ctrl #(
    parameter int TAPS = lmsaf_pkg::DEF_TAPS,
    localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int CNT_W = $clog2(TAPS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CNT_W-1:0]     len,
    input  logic                 out_free,
    output lmsaf_pkg::ctrl_t     ctrl,
    output logic [ADDR_W-1:0]    tap_addr,
    output logic [ADDR_W-1:0]    dly_addr,
    output logic [ADDR_W-1:0]    wb_addr,
    output logic [ADDR_W-1:0]    head
);

    import lmsaf_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAPS - 1);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TAPS - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] rd_reg, rd_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic              upd_reg, upd_next;
    logic              v1_reg, v1_next;
    logic              v2_reg;
    logic [ADDR_W-1:0] a1_reg;
    logic [ADDR_W-1:0] a2_reg;
    logic              last_issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            rd_reg    <= '0;
            head_reg  <= '0;
            upd_reg   <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rd_reg    <= rd_next;
            head_reg  <= head_next;
            upd_reg   <= upd_next;
            v1_reg    <= v1_next;
            v2_reg    <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= cnt_reg[ADDR_W-1:0];
        a2_reg <= a1_reg;
    end

    assign last_issue = (cnt_reg == len - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rd_next    = rd_reg;
        head_next  = head_reg;
        upd_next   = upd_reg;
        v1_next    = 1'b0;
        ctrl       = '0;
        ctrl.upd_mode = upd_reg;
        ctrl.stage2   = v2_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clearing = 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                ctrl.ready = 1'b1;
                if (start)
                begin
                    cnt_next   = '0;
                    rd_next    = head_reg;
                    upd_next   = 1'b0;
                    state_next = (len == '0) ? ST_ERR : ST_FIR;
                end
            end
            ST_FIR, ST_UPD:
            begin
                ctrl.issue = 1'b1;
                v1_next    = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                rd_next    = (rd_reg == '0) ? LAST_ADDR : rd_reg - ADDR_W'(1);
                if (last_issue)
                begin
                    state_next = (state_reg == ST_FIR) ? ST_FIR_DRAIN : ST_UPD_DRAIN;
                end
            end
            ST_FIR_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                ctrl.form_err = 1'b1;
                state_next    = ST_MUE;
            end
            ST_MUE:
            begin
                ctrl.mul_mue = 1'b1;
                state_next   = ST_LOAD_MU;
            end
            ST_LOAD_MU:
            begin
                ctrl.load_me = 1'b1;
                cnt_next     = '0;
                rd_next      = head_reg;
                upd_next     = 1'b1;
                state_next   = (len == '0) ? ST_DONE : ST_UPD;
            end
            ST_UPD_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctrl.finish = 1'b1;
                    head_next   = (head_reg == LAST_ADDR) ? '0 : head_reg + ADDR_W'(1);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    assign tap_addr = cnt_reg[ADDR_W-1:0];
    assign dly_addr = rd_reg;
    assign wb_addr  = a2_reg;
    assign head     = head_reg;

    `LMSAF_ASSERT_NEXT(a_pipe_order, v1_reg, v2_reg, "product stage lost an item")
    `LMSAF_ASSERT_SAME(a_sum_done, state_reg == ST_ERR, !v1_reg && !v2_reg,
        "error formed before the sum was complete")
    `LMSAF_ASSERT_SAME(a_wb_window, v2_reg && upd_reg,
        state_reg == ST_UPD || state_reg == ST_UPD_DRAIN,
        "coefficient written outside the update pass")
    `LMSAF_ASSERT_NEXT(a_start_step, start && state_reg == ST_IDLE,
        state_reg == ST_FIR || state_reg == ST_ERR, "accepted item did not start a pass")

endmodule

[sv/lms_adaptive_fir_top.sv]
// LMS adaptive FIR filter. Each input item carries a Q1.15 sample and a Q1.15 desired
// value; each result carries the saturated filter output y and the error desired - y.
// A single shared multiplier does all the arithmetic: one pass over the L active taps
// forms y, then one multiply forms step*error, then a second pass over the L taps
// updates the coefficients with the same regressor that produced y. The result is
// offered once the update pass is complete (both passes are skipped when no tap is
// active), and s_tready stays low until then, so no new item is taken while one is in
// progress; the next item can be taken in the same cycle that the result is offered.
// A result that the sink has not yet taken holds the block in its last step. After
// reset the block zeroes the coefficient and delay-line memories before it accepts its
// first item. Configuration writes belong between items, while no item is in progress.
module lms_adaptive_fir_top #(
    parameter int TAPS = lmsaf_pkg::DEF_TAPS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sample_in [15:0], desired_in [31:16]
    input  logic [31:0]                          s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // filter_out [15:0], error_out [31:16]
    output logic [31:0]                          m_tdata,
    input  logic                                 cfg_we,
    input  logic [lmsaf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lmsaf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import lmsaf_pkg::*;

    localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int ACC_W  = PROD_W + 1 + $clog2(TAPS);
    localparam int DL_W   = PROD_W - 16;

    localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(64'sd536870912);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sd32768);

    ctrl_t                       ctrl;
    logic                        start;
    logic                        out_free;
    logic [CNT_W-1:0]            len;
    logic [ADDR_W-1:0]           tap_addr;
    logic [ADDR_W-1:0]           dly_addr;
    logic [ADDR_W-1:0]           wb_addr;
    logic [ADDR_W-1:0]           head;

    logic [STEP_W-1:0]           step_size_reg;
    logic [TAPS_W-1:0]           taps_in_use_reg;

    logic signed [SAMPLE_W-1:0]  desired_reg;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0]  y_reg, y_next;
    logic signed [SAMPLE_W-1:0]  e_reg, e_next;
    logic signed [MUL_A_W-1:0]   me_reg;
    logic signed [COEF_W-1:0]    coef_d_reg;
    logic                        out_valid_reg;
    logic [31:0]                 out_data_reg;

    logic                        coef_we;
    logic [ADDR_W-1:0]           coef_waddr;
    logic [COEF_W-1:0]           coef_wdata;
    logic [COEF_W-1:0]           coef_rdata;
    logic                        dly_we;
    logic [ADDR_W-1:0]           dly_waddr;
    logic [SAMPLE_W-1:0]         dly_wdata;
    logic [SAMPLE_W-1:0]         dly_rdata;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]    prod;

    logic signed [ACC_W-1:0]     acc_rnd;
    logic signed [ACC_W-31:0]    y_wide;
    logic signed [SAMPLE_W:0]    e_wide;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [DL_W-1:0]      delta;
    logic signed [COEF_W+1:0]    coef_sum;
    logic signed [COEF_W-1:0]    coef_new;

    assign start    = s_tvalid && ctrl.ready;
    assign s_tready = ctrl.ready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg   <= STEP_RESET;
            taps_in_use_reg <= TAPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SIZE:   step_size_reg   <= cfg_data[STEP_W-1:0];
                REG_TAPS_IN_USE: taps_in_use_reg <= cfg_data[TAPS_W-1:0];
                default:         step_size_reg   <= step_size_reg;
            endcase
        end
    end

    always_comb
    begin
        if (int'(taps_in_use_reg) > TAPS)
        begin
            len = CNT_W'(TAPS);
        end
        else
        begin
            len = CNT_W'(taps_in_use_reg);
        end
    end

    lmsaf_ctrl #(
        .TAPS(TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .len      (len),
        .out_free (out_free),
        .ctrl     (ctrl),
        .tap_addr (tap_addr),
        .dly_addr (dly_addr),
        .wb_addr  (wb_addr),
        .head     (head)
    );

    assign dly_we    = ctrl.clearing || start;
    assign dly_waddr = ctrl.clearing ? tap_addr : head;
    assign dly_wdata = ctrl.clearing ? '0 : s_tdata[SAMPLE_W-1:0];

    assign coef_we    = ctrl.clearing || (ctrl.stage2 && ctrl.upd_mode);
    assign coef_waddr = ctrl.clearing ? tap_addr : wb_addr;
    assign coef_wdata = ctrl.clearing ? '0 : coef_new;

    lmsaf_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(TAPS)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .raddr (dly_addr),
        .rdata (dly_rdata)
    );

    lmsaf_ram #(
        .WIDTH(COEF_W),
        .DEPTH(TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (tap_addr),
        .rdata (coef_rdata)
    );

    always_comb
    begin
        if (ctrl.mul_mue)
        begin
            mul_a = $signed({{(MUL_A_W-STEP_W){1'b0}}, step_size_reg});
            mul_b = e_reg;
        end
        else if (ctrl.upd_mode)
        begin
            mul_a = me_reg;
            mul_b = $signed(dly_rdata);
        end
        else
        begin
            mul_a = $signed({coef_rdata[COEF_W-1], coef_rdata});
            mul_b = $signed(dly_rdata);
        end
    end

    lmsaf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        if (start)
        begin
            acc_next = '0;
        end
        else if (ctrl.stage2 && !ctrl.upd_mode)
        begin
            acc_next = acc_reg + $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    // Output rounds half up, then saturates; the error saturates as well.
    always_comb
    begin
        acc_rnd = acc_reg + ACC_HALF;
        y_wide  = acc_rnd[ACC_W-1:30];
        if (y_wide > $signed((ACC_W-30)'(32767)))
        begin
            y_next = 16'sh7fff;
        end
        else if (y_wide < $signed((ACC_W-30)'(-32768)))
        begin
            y_next = 16'sh8000;
        end
        else
        begin
            y_next = y_wide[SAMPLE_W-1:0];
        end
        e_wide = $signed({desired_reg[SAMPLE_W-1], desired_reg})
               - $signed({y_next[SAMPLE_W-1], y_next});
        if (e_wide > 17'sd32767)
        begin
            e_next = 16'sh7fff;
        end
        else if (e_wide < -17'sd32768)
        begin
            e_next = 16'sh8000;
        end
        else
        begin
            e_next = e_wide[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        prod_rnd = prod + PROD_HALF;
        delta    = prod_rnd[PROD_W-1:16];
        coef_sum = $signed({{2{coef_d_reg[COEF_W-1]}}, coef_d_reg})
                 + $signed({{(COEF_W+2-DL_W){delta[DL_W-1]}}, delta});
        if (coef_sum > $signed({3'b000, {(COEF_W-1){1'b1}}}))
        begin
            coef_new = {1'b0, {(COEF_W-1){1'b1}}};
        end
        else if (coef_sum < $signed({3'b111, {(COEF_W-1){1'b0}}}))
        begin
            coef_new = {1'b1, {(COEF_W-1){1'b0}}};
        end
        else
        begin
            coef_new = coef_sum[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        coef_d_reg <= $signed(coef_rdata);
        if (start)
        begin
            desired_reg <= $signed(s_tdata[31:16]);
        end
        if (ctrl.form_err)
        begin
            y_reg <= y_next;
            e_reg <= e_next;
        end
        if (ctrl.load_me)
        begin
            me_reg <= prod[MUL_A_W-1:0];
        end
        if (ctrl.finish)
        begin
            out_data_reg <= {e_reg, y_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lmsaf_pkg::*;

    localparam int TAPS        = DEF_TAPS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 530;
    localparam int DIR_ROWS    = 20;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_LEN    = 700;

    typedef struct packed {
        logic signed [15:0] err;
        logic signed [15:0] fir;
    } fir_result_t;

    typedef struct packed {
        logic               reconf;
        logic [15:0]        step;
        logic [15:0]        taps_word;
        logic signed [15:0] x;
        logic signed [15:0] d;
        logic               known;
        logic signed [15:0] y;
        logic signed [15:0] e;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic signed [31:0] coef_model [TAPS];
    logic signed [15:0] sample_hist [TAPS];
    logic [STEP_W-1:0]  step_now = STEP_RESET;
    logic [TAPS_W-1:0]  taps_now = TAPS_RESET;

    fir_result_t pending_results [$];
    int          fail_count = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          settings_count = 0;
    int          cycle_count = 0;
    logic        quiet_phase = 1'b0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, 16'd328,   16'd64,    16'sd32767,  -16'sd32768, 1'b1, 16'sd0, -16'sd32768},
        '{1'b0, 16'd328,   16'd64,   -16'sd32768,  16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd328,   16'd64,    16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd328,   16'd64,    16'sd1,      -16'sd1,     1'b0, 16'sd0, 16'sd0},
        '{1'b1, 16'd65535, 16'd64,    16'sd32767,  16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd65535, 16'd64,    16'sd32767,  16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd65535, 16'd64,    16'sd32767,  16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd65535, 16'd64,   -16'sd32768,  -16'sd32768, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd65535, 16'd64,   -16'sd32768,  16'sd32767,  1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd65535, 16'd64,    16'sd32767,  -16'sd32768, 1'b0, 16'sd0, 16'sd0},
        '{1'b1, 16'd65535, 16'h0000,  16'sd32767,  -16'sd32768, 1'b1, 16'sd0, -16'sd32768},
        '{1'b0, 16'd65535, 16'h0000, -16'sd32768,  16'sd32767,  1'b1, 16'sd0, 16'sd32767},
        '{1'b1, 16'd65535, 16'hFF7F,  16'sd12345,  -16'sd12345, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd65535, 16'hFF7F, -16'sd32768,  -16'sd32768, 1'b0, 16'sd0, 16'sd0},
        '{1'b1, 16'd0,     16'h8001,  16'sd32767,  16'sd0,      1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'd0,     16'h8001, -16'sd1,      16'sd100,    1'b0, 16'sd0, 16'sd0},
        '{1'b1, 16'd1,     16'd64,    16'sd1,      -16'sd1,     1'b0, 16'sd0, 16'sd0},
        '{1'b1, 16'hFFFF,  16'h00C0, -16'sd32768,  -16'sd32768, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 16'hFFFF,  16'h00C0,  16'sh5555,   16'sh2AAA,   1'b0, 16'sd0, 16'sd0},
        '{1'b1, 16'd328,   16'd64,    16'sd0,      16'sd0,      1'b0, 16'sd0, 16'sd0}
    };

    lms_adaptive_fir_top #(
        .TAPS(TAPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int n = 0; n < TAPS; n++)
        begin
            coef_model[n] = '0;
            sample_hist[n] = '0;
        end
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic fir_result_t lms_filter_update(input logic signed [15:0] x,
                                                      input logic signed [15:0] d);
        int          len;
        longint      acc;
        longint      yl;
        longint      el;
        longint      mu;
        longint      p;
        fir_result_t r;
        len = (int'(taps_now) > TAPS) ? TAPS : int'(taps_now);
        mu = longint'(step_now);
        for (int n = TAPS - 1; n > 0; n--)
            sample_hist[n] = sample_hist[n - 1];
        sample_hist[0] = x;
        acc = 0;
        for (int n = 0; n < len; n++)
            acc += longint'(coef_model[n]) * longint'(sample_hist[n]);
        yl = clamp((acc + (longint'(1) << 29)) >>> 30, -32768, 32767);
        el = clamp(longint'(d) - yl, -32768, 32767);
        for (int n = 0; n < len; n++)
        begin
            p = mu * el * longint'(sample_hist[n]);
            coef_model[n] = 32'(clamp(longint'(coef_model[n]) + ((p + 32768) >>> 16),
                                      -64'sd2147483648, 64'sd2147483647));
        end
        r.fir = yl[15:0];
        r.err = el[15:0];
        return r;
    endfunction

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input logic [15:0] step, input logic [15:0] taps_word);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP_SIZE;
        cfg_data  <= step;
        @(posedge clk);
        step_now = step;
        cfg_index <= REG_TAPS_IN_USE;
        cfg_data  <= taps_word;
        @(posedge clk);
        taps_now = taps_word[TAPS_W-1:0];
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic offer_item(input logic signed [15:0] x, input logic signed [15:0] d,
                              input logic known, input fir_result_t known_res);
        fir_result_t predicted;
        if (!quiet_phase && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 40)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = lms_filter_update(x, d);
        pending_results.push_back(known ? known_res : predicted);
        items_sent++;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        fir_result_t              known_res;
        logic signed [15:0]       x;
        logic signed [15:0]       d;
        logic signed [15:0]       sys_hist [4];
        longint                   sys_gain [4];
        longint                   acc;
        logic [15:0]              step;
        logic [15:0]              taps_word;
        logic [6:0]               taps_pick;
        int                       phase;
        int                       phase_len;
        int                       random_sent;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].reconf)
                write_settings(dir_rows[i].step, dir_rows[i].taps_word);
            known_res.fir = dir_rows[i].y;
            known_res.err = dir_rows[i].e;
            offer_item(dir_rows[i].x, dir_rows[i].d, dir_rows[i].known, known_res);
        end

        for (int k = 0; k < 4; k++)
            sys_hist[k] = '0;
        random_sent = 0;
        phase = 0;
        while (random_sent < RAND_ITEMS)
        begin
            case ($urandom_range(5))
                0: step = 16'd0;
                1: step = 16'hFFFF;
                2: step = STEP_RESET;
                3: step = 16'($urandom);
                default: step = 16'($urandom_range(4000, 1));
            endcase
            case ($urandom_range(9))
                0: taps_pick = 7'd0;
                1: taps_pick = 7'd1;
                2: taps_pick = 7'd64;
                3: taps_pick = 7'($urandom_range(127, 65));
                default: taps_pick = 7'($urandom_range(8, 1));
            endcase
            taps_word = 16'($urandom);
            taps_word[6:0] = taps_pick;
            if (phase == 3)
                drain_results();
            else
                write_settings(step, taps_word);
            quiet_phase = (phase == 2);
            for (int k = 0; k < 4; k++)
                sys_gain[k] = longint'($urandom_range(32768)) - 16384;
            phase_len = $urandom_range(45, 15);
            for (int j = 0; j < phase_len && random_sent < RAND_ITEMS; j++)
            begin
                x = pick_sample();
                for (int k = 3; k > 0; k--)
                    sys_hist[k] = sys_hist[k - 1];
                sys_hist[0] = x;
                if ($urandom_range(99) < 75)
                begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += sys_gain[k] * longint'(sys_hist[k]);
                    acc = (acc >>> 15) + longint'($urandom_range(64)) - 32;
                    d = 16'(clamp(acc, -32768, 32767));
                end
                else
                    d = pick_sample();
                offer_item(x, d, 1'b0, known_res);
                random_sent++;
            end
            quiet_phase = 1'b0;
            phase++;
        end

        drain_results();
        repeat (2 * TAPS + 20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            fail_count++;
            $error("%0d expected results never arrived", pending_results.size());
        end
        $display("Covered %0d items over %0d register settings; %0d results compared.",
                 items_sent, settings_count, results_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        fir_result_t got;
        fir_result_t want;
        int          hold_left;
        logic        hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $error("unexpected item: filter_out %0d error_out %0d", got.fir, got.err);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.fir !== want.fir)
                    begin
                        fail_count++;
                        $error("filter_out: expected %0d, got %0d", want.fir, got.fir);
                    end
                    if (got.err !== want.err)
                    begin
                        fail_count++;
                        $error("error_out: expected %0d, got %0d", want.err, got.err);
                    end
                end
            end
            if (!hold_done && results_seen >= HOLD_AT && s_tvalid)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet_phase)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 22);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/lmsaf_pkg.sv
sv/lmsaf_ram.sv
sv/lmsaf_mul.sv
sv/lmsaf_ctrl.sv
sv/lms_adaptive_fir_top.sv
verif/tb_top.sv
